// ===== hdl/biquad_iir_filter_saturating_defines.svh =====
// assertion helpers used by the checker file
`ifndef BIQUAD_IIR_FILTER_SATURATING_DEFINES_SVH
`define BIQUAD_IIR_FILTER_SATURATING_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BIQ_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("biquad check failed");

// next-cycle implication
`define BIQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("biquad check failed");

`endif

// ===== hdl/biq_pkg.sv =====
package biq_pkg;

	localparam int COEF_W         = 18;
	localparam int SAMPLE_W       = 16;
	localparam int X_W            = 14;
	localparam int YH_W           = 32;
	localparam int COEF_FRAC_BITS = 16;
	localparam int ACC_W          = 53;
	localparam int IDX_W          = 3;

	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [X_W-1:0]      x_t;
	typedef logic signed [YH_W-1:0]     yh_t;

	typedef struct packed {
		coef_t b0;
		coef_t b1;
		coef_t b2;
		coef_t fb1;
		coef_t fb2;
	} coef_set_t;

	typedef enum logic [IDX_W-1:0] {
		REG_B0  = 3'd0,
		REG_B1  = 3'd1,
		REG_B2  = 3'd2,
		REG_FB1 = 3'd3,
		REG_FB2 = 3'd4
	} reg_idx_t;

	localparam coef_t RST_B0  = 18'sd48591;
	localparam coef_t RST_B1  = -18'sd97182;
	localparam coef_t RST_B2  = 18'sd48591;
	localparam coef_t RST_FB1 = -18'sd92727;
	localparam coef_t RST_FB2 = 18'sd36102;

endpackage

// ===== hdl/biq_cfg.sv =====
module biq_cfg (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [biq_pkg::IDX_W-1:0] wr_index,
	input  biq_pkg::coef_t           wr_data,
	output biq_pkg::coef_set_t       coefs
);
	import biq_pkg::*;

	coef_set_t coefs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q.b0  <= RST_B0;
			coefs_q.b1  <= RST_B1;
			coefs_q.b2  <= RST_B2;
			coefs_q.fb1 <= RST_FB1;
			coefs_q.fb2 <= RST_FB2;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_B0:  coefs_q.b0  <= wr_data;
				REG_B1:  coefs_q.b1  <= wr_data;
				REG_B2:  coefs_q.b2  <= wr_data;
				REG_FB1: coefs_q.fb1 <= wr_data;
				REG_FB2: coefs_q.fb2 <= wr_data;
				default: ;
			endcase
		end
	end

	assign coefs = coefs_q;

endmodule

// ===== hdl/biq_core.sv =====
module biq_core (
	input  logic               clk,
	input  logic               arst_n,
	input  biq_pkg::coef_set_t coefs,
	input  logic               step,
	input  biq_pkg::x_t        x_in,
	input  logic               out_ready,
	output logic               out_free,
	output logic               out_valid,
	output biq_pkg::sample_t   out_sample
);
	import biq_pkg::*;

	localparam int FF_W  = COEF_W + X_W;
	localparam int FFS_W = FF_W + 2;
	localparam int FB_W  = COEF_W + YH_W;
	localparam int YF_W  = ACC_W - COEF_FRAC_BITS;
	localparam int Q_W   = YH_W - 8;

	x_t  x1_q, x2_q;
	yh_t y1_q, y2_q;
	logic    valid_q;
	sample_t sample_q;

	logic signed [FF_W-1:0]  ff0, ff1, ff2;
	logic signed [FFS_W-1:0] ff_sum;
	logic signed [FB_W-1:0]  fbp1, fbp2;
	logic signed [ACC_W-1:0] acc;
	logic signed [YF_W-1:0]  y_full;
	yh_t                     y_sat;
	logic signed [Q_W-1:0]   q_trunc;
	sample_t                 o_sat;

	assign ff0  = coefs.b0 * x_in;
	assign ff1  = coefs.b1 * x1_q;
	assign ff2  = coefs.b2 * x2_q;
	assign fbp1 = coefs.fb1 * y1_q;
	assign fbp2 = coefs.fb2 * y2_q;

	assign ff_sum = {{2{ff0[FF_W-1]}}, ff0} + {{2{ff1[FF_W-1]}}, ff1}
		+ {{2{ff2[FF_W-1]}}, ff2};

	assign acc = {{(ACC_W-FFS_W-8){ff_sum[FFS_W-1]}}, ff_sum, 8'b0}
		- {{(ACC_W-FB_W){fbp1[FB_W-1]}}, fbp1}
		- {{(ACC_W-FB_W){fbp2[FB_W-1]}}, fbp2};

	// floor shift: dropping the low bits of a two's complement value
	assign y_full = acc[ACC_W-1:COEF_FRAC_BITS];

	always_comb begin
		if (&y_full[YF_W-1:YH_W-1] || ~|y_full[YF_W-1:YH_W-1]) begin
			y_sat = y_full[YH_W-1:0];
		end else if (y_full[YF_W-1]) begin
			y_sat = {1'b1, {(YH_W-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(YH_W-1){1'b1}}};
		end
	end

	// divide by 256 rounding toward zero
	always_comb begin
		q_trunc = y_sat[YH_W-1:8];
		if (y_sat[YH_W-1] && |y_sat[7:0]) begin
			q_trunc = q_trunc + Q_W'(1);
		end
	end

	always_comb begin
		if (&q_trunc[Q_W-1:SAMPLE_W-1] || ~|q_trunc[Q_W-1:SAMPLE_W-1]) begin
			o_sat = q_trunc[SAMPLE_W-1:0];
		end else if (q_trunc[Q_W-1]) begin
			o_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			o_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	assign out_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q    <= '0;
			x2_q    <= '0;
			y1_q    <= '0;
			y2_q    <= '0;
			valid_q <= 1'b0;
		end else begin
			if (step) begin
				x1_q <= x_in;
				x2_q <= x1_q;
				y1_q <= y_sat;
				y2_q <= y1_q;
			end
			if (out_free) begin
				valid_q <= step;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			sample_q <= o_sat;
		end
	end

	assign out_valid  = valid_q;
	assign out_sample = sample_q;

endmodule

// ===== hdl/biquad_iir_filter_saturating.sv =====
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[15:0] sample_in
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata[15:0] sample_out
// cfg       in   cfg_valid/cfg_ready          cfg_index[2:0], cfg_data[17:0]
//
// One sample per cycle unless the output stalls; input and output are registered.
// The feedback loop (two 18x32 multiplies, sum, saturation) sets the clock period.
// Reset clears histories and valids and loads the high-pass coefficient set.
// A stalled output holds its sample; the input register keeps accepting while
// the output register is free or being drained. cfg_ready is always high.
module biquad_iir_filter_saturating (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [15:0]               s_axis_tdata,  // [15:0] sample_in
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [15:0]               m_axis_tdata,  // [15:0] sample_out
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [biq_pkg::IDX_W-1:0] cfg_index,
	input  logic [17:0]               cfg_data
);
	import biq_pkg::*;

	coef_set_t coefs;
	x_t        x_s1;
	logic      valid_s1;
	logic      out_free;
	logic      step;
	sample_t   out_sample;

	assign cfg_ready = 1'b1;

	biq_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (coef_t'(cfg_data)),
		.coefs    (coefs)
	);

	assign step          = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// arithmetic shift right by two
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			x_s1 <= s_axis_tdata[15:2];
		end
	end

	biq_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.coefs      (coefs),
		.step       (step),
		.x_in       (x_s1),
		.out_ready  (m_axis_tready),
		.out_free   (out_free),
		.out_valid  (m_axis_tvalid),
		.out_sample (out_sample)
	);

	assign m_axis_tdata = out_sample;

endmodule

// ===== hdl/biq_checker.sv =====
`include "biquad_iir_filter_saturating_defines.svh"

module biq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [15:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [2:0]  cfg_index,
	input logic [17:0] cfg_data
);

	`BIQ_ASSERT_NEXT(out_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`BIQ_ASSERT_NEXT(out_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`BIQ_ASSERT_SAME(cfg_never_stalls, 1'b1, cfg_ready)
	`BIQ_ASSERT_SAME(empty_accepts, !m_axis_tvalid, s_axis_tready)
	`BIQ_ASSERT_SAME(two_cycle_latency, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2))

endmodule

bind biquad_iir_filter_saturating biq_checker u_biq_checker (.*);
